@@ hw/rtl/ssa_pkg.sv @@
`default_nettype none
package ssa_pkg;

  localparam int FRAMES    = 16;
  localparam int FRAME_W   = 4;
  localparam int MAX_SLOTS = 128;
  localparam int SLOT_W    = 7;
  localparam int CNT_W     = 8;
  localparam int PTR_W     = 5;
  localparam int SADDR_W   = FRAME_W + SLOT_W;
  localparam int LIVE_W    = 12;
  localparam int PIU_W     = 5;

  localparam logic [PTR_W-1:0] LIST_NULL = PTR_W'(FRAMES);
  localparam logic [CNT_W-1:0] MIN_SLOTS = CNT_W'(4);
  localparam logic [CNT_W-1:0] TOP_SLOTS = CNT_W'(MAX_SLOTS);

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_NOPAGE = 2'd1;
  localparam logic [1:0] STS_DOUBLE = 2'd2;
  localparam logic [1:0] STS_BADH   = 2'd3;

  // per-frame record: stack top, fresh-region mark, free slot count
  typedef struct packed {
    logic [SLOT_W-1:0] top;
    logic [CNT_W-1:0]  mark;
    logic [CNT_W-1:0]  free;
  } rec_t;

  typedef struct packed {
    logic [SLOT_W-1:0] link;
    logic              taken;
  } slot_word_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
    rec_t               data;
  } rec_wr_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
    logic [PTR_W-1:0]   data;
  } ptr_wr_t;

  typedef struct packed {
    logic               en;
    logic [SADDR_W-1:0] addr;
    slot_word_t         data;
  } slot_wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/ssa_slot_ram.sv @@
`default_nettype none
module ssa_slot_ram (
  input  wire                            clk,
  input  wire                            rd_en,
  input  wire  [ssa_pkg::SADDR_W-1:0]    rd_addr,
  input  ssa_pkg::slot_wr_t              wr,
  output ssa_pkg::slot_word_t            rd_data
);
  import ssa_pkg::*;

  slot_word_t mem [FRAMES*MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ssa_page_ram.sv @@
`default_nettype none
module ssa_page_ram (
  input  wire                            clk,
  input  wire                            rd_en,
  input  wire  [ssa_pkg::FRAME_W-1:0]    rd_addr,
  input  ssa_pkg::rec_wr_t               rec_wr,
  input  ssa_pkg::ptr_wr_t               nxt_wr,
  input  ssa_pkg::ptr_wr_t               prv_wr,
  output ssa_pkg::rec_t                  rec_q,
  output logic [ssa_pkg::PTR_W-1:0]      nxt_q,
  output logic [ssa_pkg::PTR_W-1:0]      prv_q
);
  import ssa_pkg::*;

  rec_t             rec_mem [FRAMES];
  logic [PTR_W-1:0] nxt_mem [FRAMES];
  logic [PTR_W-1:0] prv_mem [FRAMES];

  always_ff @(posedge clk) begin
    if (rec_wr.en) begin
      rec_mem[rec_wr.addr] <= rec_wr.data;
    end
    if (nxt_wr.en) begin
      nxt_mem[nxt_wr.addr] <= nxt_wr.data;
    end
    if (prv_wr.en) begin
      prv_mem[prv_wr.addr] <= prv_wr.data;
    end
    if (rd_en) begin
      rec_q <= rec_mem[rd_addr];
      nxt_q <= nxt_mem[rd_addr];
      prv_q <= prv_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/slab_slot_allocator_unit.sv @@
// Sequence: clear, unused mode, bad handle, pool empty and first alloc of a fresh frame
//   go straight to S_OUT; alloc reads the page table in S_A1 (and slot memory in S_A2 if
//   the slot stack must be followed); free uses S_F1 (and S_F2 to join a non-empty list tail).
// Flow: one transaction at a time; in_stall holds new requests through the page-table
//   and slot-memory read-modify-write sequence until the result reaches the output register.
// Reset: synchronous active-low rst_n empties the pool; no clearing pass is needed.
`default_nettype none
module slab_slot_allocator_unit (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire  [7:0]                    cfg_wdata,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [1:0]                    in_mode,
  input  wire  [ssa_pkg::FRAME_W-1:0]   in_free_page,
  input  wire  [ssa_pkg::SLOT_W-1:0]    in_free_slot,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [1:0]                    out_status,
  output logic [ssa_pkg::FRAME_W-1:0]   out_got_page,
  output logic [ssa_pkg::SLOT_W-1:0]    out_got_slot,
  output logic [ssa_pkg::LIVE_W-1:0]    out_live_items,
  output logic [ssa_pkg::PIU_W-1:0]     out_pages_in_use
);
  import ssa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_A1   = 3'd1;
  localparam logic [2:0] S_A2   = 3'd2;
  localparam logic [2:0] S_F1   = 3'd3;
  localparam logic [2:0] S_F2   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   ipp_r, ipp_nxt;
  logic [FRAMES-1:0]  claimed_r, claimed_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [LIVE_W-1:0]  items_r, items_nxt;
  logic [PIU_W-1:0]   frames_r, frames_nxt;
  logic [FRAME_W-1:0] page_r, page_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [FRAME_W-1:0] tail_old_r, tail_old_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [FRAME_W-1:0] res_page_r, res_page_nxt;
  logic [SLOT_W-1:0]  res_slot_r, res_slot_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r;
  logic [FRAME_W-1:0] out_page_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [LIVE_W-1:0]  out_live_r;
  logic [PIU_W-1:0]   out_piu_r;

  logic               in_accept, out_load;
  logic [CNT_W-1:0]   nslots;
  logic               any_free;
  logic [FRAME_W-1:0] free_idx;

  logic               pg_rd_en;
  logic [FRAME_W-1:0] pg_rd_addr;
  rec_wr_t            rec_wr;
  ptr_wr_t            nxt_wr, prv_wr;
  rec_t               rec_q;
  logic [PTR_W-1:0]   nxt_q, prv_q;
  logic               sl_rd_en;
  logic [SADDR_W-1:0] sl_rd_addr;
  slot_wr_t           sl_wr;
  slot_word_t         sl_q;

  logic [SLOT_W-1:0]  a_s, a_top;
  logic               a_fresh, a_commit;
  logic [CNT_W-1:0]   a_mark, a_free;
  logic               f_taken;
  logic [CNT_W-1:0]   f_free;

  ssa_page_ram u_page (
    .clk     (clk),
    .rd_en   (pg_rd_en),
    .rd_addr (pg_rd_addr),
    .rec_wr  (rec_wr),
    .nxt_wr  (nxt_wr),
    .prv_wr  (prv_wr),
    .rec_q   (rec_q),
    .nxt_q   (nxt_q),
    .prv_q   (prv_q)
  );

  ssa_slot_ram u_slot (
    .clk     (clk),
    .rd_en   (sl_rd_en),
    .rd_addr (sl_rd_addr),
    .wr      (sl_wr),
    .rd_data (sl_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = !out_valid_r || !out_stall;

  always_comb begin
    if (ipp_r < MIN_SLOTS) begin
      nslots = MIN_SLOTS;
    end else if (ipp_r > TOP_SLOTS) begin
      nslots = TOP_SLOTS;
    end else begin
      nslots = ipp_r;
    end
  end

  // lowest unclaimed frame
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!claimed_r[i]) begin
        any_free = 1'b1;
        free_idx = FRAME_W'(i);
      end
    end
  end

  // slots below mark were never handed out: implicitly free, stacked downward
  assign a_s     = rec_q.top;
  assign a_fresh = {1'b0, a_s} < rec_q.mark;
  assign a_top   = a_fresh ? a_s - SLOT_W'(1) : sl_q.link;
  assign a_mark  = a_fresh ? {1'b0, a_s} : rec_q.mark;
  assign a_free  = rec_q.free - CNT_W'(1);
  assign a_commit = ((state_r == S_A1) && a_fresh) || (state_r == S_A2);

  assign f_taken = sl_q.taken && ({1'b0, slot_r} >= rec_q.mark);
  assign f_free  = rec_q.free + CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    ipp_nxt        = ipp_r;
    claimed_nxt    = claimed_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    items_nxt      = items_r;
    frames_nxt     = frames_r;
    page_nxt       = page_r;
    slot_nxt       = slot_r;
    tail_old_nxt   = tail_old_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_slot_nxt   = res_slot_r;
    pg_rd_en       = 1'b0;
    pg_rd_addr     = page_r;
    sl_rd_en       = 1'b0;
    sl_rd_addr     = {page_r, slot_r};
    rec_wr         = '0;
    nxt_wr         = '0;
    prv_wr         = '0;
    sl_wr          = '0;

    if (cfg_we && (frames_r == '0)) begin
      ipp_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_status_nxt = STS_OK;
          res_page_nxt   = '0;
          res_slot_nxt   = '0;
          slot_nxt       = in_free_slot;
          page_nxt       = in_free_page;
          state_nxt      = S_OUT;
          case (in_mode)
            MODE_ALLOC: begin
              if (head_r != LIST_NULL) begin
                page_nxt   = head_r[FRAME_W-1:0];
                pg_rd_en   = 1'b1;
                pg_rd_addr = head_r[FRAME_W-1:0];
                state_nxt  = S_A1;
              end else if (any_free) begin
                // claim and pop the top fresh slot in one go
                rec_wr.en        = 1'b1;
                rec_wr.addr      = free_idx;
                rec_wr.data.top  = SLOT_W'(nslots - CNT_W'(2));
                rec_wr.data.mark = nslots - CNT_W'(1);
                rec_wr.data.free = nslots - CNT_W'(1);
                nxt_wr           = '{en: 1'b1, addr: free_idx, data: LIST_NULL};
                prv_wr           = '{en: 1'b1, addr: free_idx, data: LIST_NULL};
                sl_wr.en         = 1'b1;
                sl_wr.addr       = {free_idx, SLOT_W'(nslots - CNT_W'(1))};
                sl_wr.data       = '{link: '0, taken: 1'b1};
                head_nxt         = {1'b0, free_idx};
                tail_nxt         = {1'b0, free_idx};
                claimed_nxt[free_idx] = 1'b1;
                frames_nxt       = frames_r + PIU_W'(1);
                items_nxt        = items_r + LIVE_W'(1);
                res_page_nxt     = free_idx;
                res_slot_nxt     = SLOT_W'(nslots - CNT_W'(1));
              end else begin
                res_status_nxt = STS_NOPAGE;
              end
            end
            MODE_FREE: begin
              if (!claimed_r[in_free_page] || ({1'b0, in_free_slot} >= nslots)) begin
                res_status_nxt = STS_BADH;
              end else begin
                pg_rd_en   = 1'b1;
                pg_rd_addr = in_free_page;
                sl_rd_en   = 1'b1;
                sl_rd_addr = {in_free_page, in_free_slot};
                state_nxt  = S_F1;
              end
            end
            MODE_CLEAR: begin
              claimed_nxt = '0;
              head_nxt    = LIST_NULL;
              tail_nxt    = LIST_NULL;
              items_nxt   = '0;
              frames_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_A1: begin
        if (!a_fresh) begin
          sl_rd_en   = 1'b1;
          sl_rd_addr = {page_r, a_s};
          state_nxt  = S_A2;
        end
      end

      S_A2: begin
        state_nxt = S_A2;
      end

      S_F1: begin
        state_nxt = S_OUT;
        if (!f_taken) begin
          res_status_nxt = STS_DOUBLE;
        end else begin
          items_nxt = items_r - LIVE_W'(1);
          if (f_free == nslots) begin
            // last live slot: release the frame
            if (prv_q == LIST_NULL) begin
              head_nxt = nxt_q;
            end else begin
              nxt_wr = '{en: 1'b1, addr: prv_q[FRAME_W-1:0], data: nxt_q};
            end
            if (nxt_q == LIST_NULL) begin
              tail_nxt = prv_q;
            end else begin
              prv_wr = '{en: 1'b1, addr: nxt_q[FRAME_W-1:0], data: prv_q};
            end
            claimed_nxt[page_r] = 1'b0;
            frames_nxt = frames_r - PIU_W'(1);
          end else begin
            sl_wr.en         = 1'b1;
            sl_wr.addr       = {page_r, slot_r};
            sl_wr.data       = '{link: rec_q.top, taken: 1'b0};
            rec_wr.en        = 1'b1;
            rec_wr.addr      = page_r;
            rec_wr.data.top  = slot_r;
            rec_wr.data.mark = rec_q.mark;
            rec_wr.data.free = f_free;
            if (rec_q.free == '0) begin
              // frame was full: append at tail
              nxt_wr = '{en: 1'b1, addr: page_r, data: LIST_NULL};
              prv_wr = '{en: 1'b1, addr: page_r, data: tail_r};
              if (tail_r == LIST_NULL) begin
                head_nxt = {1'b0, page_r};
              end else begin
                tail_old_nxt = tail_r[FRAME_W-1:0];
                state_nxt    = S_F2;
              end
              tail_nxt = {1'b0, page_r};
            end
          end
        end
      end

      S_F2: begin
        nxt_wr    = '{en: 1'b1, addr: tail_old_r, data: {1'b0, page_r}};
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (a_commit) begin
      rec_wr.en        = 1'b1;
      rec_wr.addr      = page_r;
      rec_wr.data.top  = a_top;
      rec_wr.data.mark = a_mark;
      rec_wr.data.free = a_free;
      sl_wr.en         = 1'b1;
      sl_wr.addr       = {page_r, a_s};
      sl_wr.data       = '{link: '0, taken: 1'b1};
      items_nxt        = items_r + LIVE_W'(1);
      res_status_nxt   = STS_OK;
      res_page_nxt     = page_r;
      res_slot_nxt     = a_s;
      state_nxt        = S_OUT;
      if (a_free == '0) begin
        // frame is the list head, so it has no predecessor
        head_nxt = nxt_q;
        if (nxt_q == LIST_NULL) begin
          tail_nxt = LIST_NULL;
        end else begin
          prv_wr = '{en: 1'b1, addr: nxt_q[FRAME_W-1:0], data: LIST_NULL};
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((state_r == S_OUT) && out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ipp_r       <= TOP_SLOTS;
      claimed_r   <= '0;
      head_r      <= LIST_NULL;
      tail_r      <= LIST_NULL;
      items_r     <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ipp_r       <= ipp_nxt;
      claimed_r   <= claimed_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      items_r     <= items_nxt;
      frames_r    <= frames_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    slot_r       <= slot_nxt;
    tail_old_r   <= tail_old_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_slot_r   <= res_slot_nxt;
    if ((state_r == S_OUT) && out_load) begin
      out_status_r <= res_status_r;
      out_page_r   <= res_page_r;
      out_slot_r   <= res_slot_r;
      out_live_r   <= items_r;
      out_piu_r    <= frames_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_got_page     = out_page_r;
  assign out_got_slot     = out_slot_r;
  assign out_live_items   = out_live_r;
  assign out_pages_in_use = out_piu_r;

  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == LIST_NULL) == (tail_r == LIST_NULL))
    else $error("partial list head and tail disagree on emptiness");

  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(frames_r) == $countones(claimed_r))
    else $error("frame counter out of step with claimed frames");

  a_head_claimed: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != LIST_NULL) |-> claimed_r[head_r[FRAME_W-1:0]])
    else $error("partial list head is not a claimed frame");

  a_cfg_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (frames_r != '0) |=> $stable(ipp_r))
    else $error("slot count changed while frames are claimed");

endmodule
`default_nettype wire

@@ test/tb_slab_slot_allocator_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_slab_slot_allocator_unit;
  import ssa_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_ALLOC;
  logic [FRAME_W-1:0] in_free_page = '0;
  logic [SLOT_W-1:0] in_free_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [FRAME_W-1:0] out_got_page;
  logic [SLOT_W-1:0] out_got_slot;
  logic [LIVE_W-1:0] out_live_items;
  logic [PIU_W-1:0] out_pages_in_use;

  slab_slot_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_free_page(in_free_page), .in_free_slot(in_free_slot),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_got_page(out_got_page), .out_got_slot(out_got_slot),
    .out_live_items(out_live_items), .out_pages_in_use(out_pages_in_use)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [1:0] status;
    logic [FRAME_W-1:0] page;
    logic [SLOT_W-1:0] slot;
    logic [LIVE_W-1:0] live;
    logic [PIU_W-1:0] frames;
  } alloc_result_t;

  alloc_result_t expected_results[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit rx_idle_en = 1'b1;
  bit long_hold = 1'b0;

  // shadow allocator state
  logic [7:0] per_page_reg;
  logic [SLOT_W-1:0] sh_link[FRAMES*MAX_SLOTS];
  bit sh_taken[FRAMES*MAX_SLOTS];
  logic [SLOT_W-1:0] sh_top[FRAMES];
  int sh_free[FRAMES];
  bit sh_claimed[FRAMES];
  int sh_next[FRAMES];
  int sh_prev[FRAMES];
  int sh_head, sh_tail;
  int sh_items, sh_frames;

  function automatic int eff_slots();
    int n;
    n = per_page_reg;
    if (n < 4) n = 4;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  function automatic void unlink_frame(int f);
    int p, n;
    p = sh_prev[f];
    n = sh_next[f];
    if (p == FRAMES) sh_head = n; else sh_next[p] = n;
    if (n == FRAMES) sh_tail = p; else sh_prev[n] = p;
  endfunction

  function automatic alloc_result_t predict_alloc(logic [1:0] mode, int page, int slot);
    alloc_result_t r;
    int f, s, i, n;
    r = '0;
    n = eff_slots();
    if (mode == MODE_ALLOC) begin
      if (sh_head == FRAMES) begin
        for (f = 0; f < FRAMES; f++) if (!sh_claimed[f]) break;
        if (f < FRAMES) begin
          for (s = 0; s < n; s++) begin
            sh_taken[f*MAX_SLOTS+s] = 0;
            sh_link[f*MAX_SLOTS+s] = SLOT_W'((s == 0) ? 0 : s - 1);
          end
          sh_top[f] = SLOT_W'(n - 1);
          sh_free[f] = n;
          sh_claimed[f] = 1;
          sh_frames++;
          sh_prev[f] = FRAMES;
          sh_next[f] = FRAMES;
          sh_head = f;
          sh_tail = f;
        end
      end
      if (sh_head == FRAMES) r.status = STS_NOPAGE;
      else begin
        f = sh_head;
        s = sh_top[f];
        i = f*MAX_SLOTS + s;
        sh_top[f] = sh_link[i];
        sh_taken[i] = 1;
        sh_free[f]--;
        sh_items++;
        if (sh_free[f] == 0) unlink_frame(f);
        r.page = FRAME_W'(f);
        r.slot = SLOT_W'(s);
      end
    end else if (mode == MODE_FREE) begin
      if (!sh_claimed[page] || slot >= n) r.status = STS_BADH;
      else begin
        i = page*MAX_SLOTS + slot;
        if (!sh_taken[i]) r.status = STS_DOUBLE;
        else begin
          sh_items--;
          if (sh_free[page] + 1 == n) begin
            unlink_frame(page);
            sh_claimed[page] = 0;
            sh_frames--;
          end else begin
            sh_taken[i] = 0;
            sh_link[i] = sh_top[page];
            sh_top[page] = SLOT_W'(slot);
            sh_free[page]++;
            if (sh_free[page] == 1) begin
              sh_next[page] = FRAMES;
              sh_prev[page] = sh_tail;
              if (sh_tail == FRAMES) sh_head = page; else sh_next[sh_tail] = page;
              sh_tail = page;
            end
          end
        end
      end
    end else if (mode == MODE_CLEAR) begin
      for (f = 0; f < FRAMES; f++) sh_claimed[f] = 0;
      sh_head = FRAMES;
      sh_tail = FRAMES;
      sh_items = 0;
      sh_frames = 0;
    end
    r.live = sh_items[LIVE_W-1:0];
    r.frames = sh_frames[PIU_W-1:0];
    return r;
  endfunction

  task automatic send_request(logic [1:0] mode, int page, int slot);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_free_page <= FRAME_W'(page);
    in_free_slot <= SLOT_W'(slot);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_alloc(mode, page, slot));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_per_page(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sh_frames == 0) per_page_reg = v;
    @(posedge clk);
  endtask

  // free a random live item, or any random handle now and then
  task automatic free_something(bit allow_bad);
    int f, s, tries;
    f = 0;
    s = 0;
    for (tries = 0; tries < 40; tries++) begin
      f = $urandom_range(0, FRAMES-1);
      s = $urandom_range(0, eff_slots()-1);
      if (sh_claimed[f] && sh_taken[f*MAX_SLOTS+s]) break;
    end
    if (allow_bad) begin
      f = $urandom_range(0, FRAMES-1);
      s = $urandom_range(0, 127);
    end
    send_request(MODE_FREE, f, s);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d", $time, out_status);
          errors++;
        end else begin
          alloc_result_t e;
          e = expected_results.pop_front();
          if (out_status !== e.status || out_got_page !== e.page ||
              out_got_slot !== e.slot || out_live_items !== e.live ||
              out_pages_in_use !== e.frames) begin
            $display("%0t: mismatch expected st=%0d pg=%0d sl=%0d live=%0d pages=%0d",
                     $time, e.status, e.page, e.slot, e.live, e.frames);
            $display("%0t:            actual st=%0d pg=%0d sl=%0d live=%0d pages=%0d",
                     $time, out_status, out_got_page, out_got_slot, out_live_items,
                     out_pages_in_use);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall: random bursts, or one long hold-off
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (long_hold) begin
      if (hold_cnt >= 60) begin
        long_hold <= 1'b0;
        hold_cnt <= 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end
    end else if (out_stall) begin
      out_stall <= ($urandom_range(0, 2) != 0) && !quiet;
    end else if (rx_idle_en && !quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
    end
  end

  task automatic test_directed();
    int k;
    send_request(MODE_FREE, 0, 0);       // bad handle, unclaimed frame
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 0, 127);     // slot beyond the clamped count
    send_request(MODE_FREE, 0, 3);       // frees a live slot
    send_request(MODE_FREE, 0, 2);       // frees the last live slot, releasing the frame
    send_request(MODE_NOP, 15, 127);     // unused mode
    send_request(MODE_FREE, 0, 2);       // bad handle, frame no longer claimed
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 0, 1);       // never handed out
    send_request(MODE_FREE, 0, 0);
    send_request(MODE_FREE, 0, 3);
    send_request(MODE_FREE, 0, 2);       // last one releases the frame
    for (k = 0; k < 8; k++) send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_CLEAR, 0, 0);
    drain();
  endtask

  task automatic test_exhaust();
    int k;
    // 4 slots per frame: 64 allocs fill the pool, then it runs dry
    for (k = 0; k < 66; k++) send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 15, 3);
    send_request(MODE_FREE, 7, 0);
    send_request(MODE_ALLOC, 0, 0);
    drain();
    write_per_page(8'd40);               // ignored while frames are claimed
    send_request(MODE_CLEAR, 0, 0);
    drain();
  endtask

  task automatic test_random(int count, bit allow_clear);
    int k, r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_request(MODE_ALLOC, $urandom_range(0, 15), $urandom_range(0, 127));
      else if (r < 88) free_something(1'b0);
      else if (r < 96) free_something(1'b1);
      else if (r < 98 && allow_clear) send_request(MODE_CLEAR, 0, 0);
      else send_request(MODE_NOP, $urandom_range(0, 15), $urandom_range(0, 127));
    end
  endtask

  task automatic test_backpressure();
    long_hold <= 1'b1;
    test_random(30, 1'b0);
    drain();
  endtask

  task automatic test_sender_pause();
    test_random(20, 1'b0);
    drain();
    test_random(20, 1'b1);
    send_request(MODE_CLEAR, 0, 0);
    drain();
  endtask

  initial begin
    int f;
    per_page_reg = 8'd128;
    for (f = 0; f < FRAMES; f++) sh_claimed[f] = 0;
    sh_head = FRAMES;
    sh_tail = FRAMES;
    sh_items = 0;
    sh_frames = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_per_page(8'd0);                // clamps up to 4
    test_directed();
    test_exhaust();
    write_per_page(8'd255);              // clamps down to 128
    test_random(120, 1'b0);
    send_request(MODE_CLEAR, 0, 0);
    drain();
    write_per_page(8'd5);
    test_backpressure();
    test_sender_pause();
    write_per_page(8'd4);
    test_random(150, 1'b1);
    send_request(MODE_CLEAR, 0, 0);
    drain();
    write_per_page(8'd13);
    quiet = 1'b1;
    test_random(120, 1'b1);
    drain();
    if (errors == 0) $display("PASS slab_slot_allocator_unit");
    else $display("FAIL slab_slot_allocator_unit");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL slab_slot_allocator_unit");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_slot_ram.sv
hw/rtl/ssa_page_ram.sv
hw/rtl/slab_slot_allocator_unit.sv
test/tb_slab_slot_allocator_unit.sv
